### rtl/core/dmadx_pkg.sv
// ----------------------------------------------------------------------------
// dmadx_pkg: shared types and constants of the directional movement block
// Field widths, fixed-point constants, phase codes and the structs that
// travel between the sequencer, the divider and the top level.
// ----------------------------------------------------------------------------
package dmadx_pkg;

	localparam int PRICE_BITS   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int COUNT_BITS   = 13;
	localparam int PERIOD_BITS  = 12;
	localparam int OUT_BITS     = 23;
	localparam int SMOOTH_BITS  = 60;
	localparam int MOVE_BITS    = PRICE_BITS + FRAC_BITS;
	localparam int DXT_BITS     = 36;
	// Growth of a value multiplied by 100.
	localparam int HUNDRED_BITS = 7;

	// Shared divider: dividend, quotient and step counter widths.
	localparam int DIV_N_BITS   = 84;
	localparam int DIV_Q_BITS   = SMOOTH_BITS + 1;
	localparam int NARROW_STEPS = DIV_N_BITS - SMOOTH_BITS;
	localparam int STEP_BITS    = 6;

	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);
	localparam logic [OUT_BITS-1:0]    FULL         = OUT_BITS'(100 << FRAC_BITS);

	localparam logic [1:0] PHASE_WARM    = 2'd0;
	localparam logic [1:0] PHASE_PARTIAL = 2'd1;
	localparam logic [1:0] PHASE_SMOOTH  = 2'd2;

	typedef struct packed {
		logic [PRICE_BITS-1:0] bar_high;
		logic [PRICE_BITS-1:0] bar_low;
		logic [PRICE_BITS-1:0] bar_close;
		logic                  restart;
	} bar_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] adx_value;
		logic [OUT_BITS-1:0] plus_di;
		logic [OUT_BITS-1:0] minus_di;
		logic [1:0]          phase;
	} result_t;

	typedef struct packed {
		logic start;
		logic narrow;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIV_Q_BITS-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic busy;
		logic fin;
	} seq_status_t;

endpackage

### rtl/core/dmadx_div.sv
// ----------------------------------------------------------------------------
// dmadx_div: shared bit-serial divider
// Restoring long division, one quotient bit per cycle. A wide request runs
// 61 steps with no limit on the quotient; a narrow request runs 24 steps and
// its quotient saturates at 100.0 in Q7.16. A zero divisor gives zero.
// ----------------------------------------------------------------------------
module dmadx_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dmadx_pkg::div_req_t                  req,
	input  logic [dmadx_pkg::DIV_N_BITS-1:0]     dividend,
	input  logic [dmadx_pkg::SMOOTH_BITS-1:0]    divisor,
	output dmadx_pkg::div_rsp_t                  rsp
);

	localparam int DN = dmadx_pkg::DIV_N_BITS;
	localparam int DQ = dmadx_pkg::DIV_Q_BITS;
	localparam int SB = dmadx_pkg::SMOOTH_BITS;
	localparam int NS = dmadx_pkg::NARROW_STEPS;
	localparam int OB = dmadx_pkg::OUT_BITS;
	localparam int CB = dmadx_pkg::STEP_BITS;
	localparam logic [DQ-1:0] FULL_Q = {{(DQ-OB){1'b0}}, dmadx_pkg::FULL};

	logic          busy_q;
	logic          done_q;
	logic [CB-1:0] cnt_q;
	logic          narrow_q;
	logic [SB-1:0] r_q;
	logic [SB-1:0] d_q;
	logic [DN-1:0] n_q;
	logic [DQ-1:0] q_q;

	logic [SB-1:0] r_init;
	logic          sat_init;
	logic [DQ-1:0] r_shift;
	logic [DQ-1:0] r_diff;
	logic          r_ge;

	assign r_init   = req.narrow ? dividend[DN-1:NS] : '0;
	assign sat_init = req.narrow && (dividend[DN-1:NS] >= divisor);

	assign r_shift = {r_q, n_q[DN-1]};
	assign r_ge    = r_shift >= {1'b0, d_q};
	assign r_diff  = r_shift - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (divisor == '0 || sat_init) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= req.narrow ? CB'(NS) : CB'(DQ);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CB'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			narrow_q <= req.narrow;
			d_q      <= divisor;
			r_q      <= r_init;
			n_q      <= req.narrow ? {dividend[NS-1:0], {SB{1'b0}}}
			                       : {dividend[DQ-1:0], {(DN-DQ){1'b0}}};
			if (divisor == '0) begin
				q_q <= '0;
			end else if (sat_init) begin
				q_q <= FULL_Q;
			end else begin
				q_q <= '0;
			end
		end else if (busy_q) begin
			r_q <= r_ge ? r_diff[SB-1:0] : r_shift[SB-1:0];
			n_q <= {n_q[DN-2:0], 1'b0};
			q_q <= {q_q[DQ-2:0], r_ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = (narrow_q && q_q > FULL_Q) ? FULL_Q : q_q;

endmodule

### rtl/core/dmadx_seq.sv
// ----------------------------------------------------------------------------
// dmadx_seq: per-bar sequencer and series state
// Holds the previous bar, the bar count and the smoothed sums, computes true
// range and directional moves, and drives the shared divider through the
// Wilder updates, both DI values, DX and the ADX average.
// ----------------------------------------------------------------------------
module dmadx_seq (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 bar_accept,
	input  dmadx_pkg::bar_t                      bar,
	input  logic [dmadx_pkg::PERIOD_BITS-1:0]    period,
	input  logic                                 take,
	output dmadx_pkg::seq_status_t               status,
	output dmadx_pkg::result_t                   result
);

	localparam int PB = dmadx_pkg::PRICE_BITS;
	localparam int FB = dmadx_pkg::FRAC_BITS;
	localparam int CB = dmadx_pkg::COUNT_BITS;
	localparam int TB = dmadx_pkg::PERIOD_BITS;
	localparam int OB = dmadx_pkg::OUT_BITS;
	localparam int SB = dmadx_pkg::SMOOTH_BITS;
	localparam int MB = dmadx_pkg::MOVE_BITS;
	localparam int XB = dmadx_pkg::DXT_BITS;
	localparam int HB = dmadx_pkg::HUNDRED_BITS;
	localparam int DN = dmadx_pkg::DIV_N_BITS;
	localparam int DQ = dmadx_pkg::DIV_Q_BITS;
	localparam logic [DQ-1:0] FULL_Q = {{(DQ-OB){1'b0}}, dmadx_pkg::FULL};

	localparam logic [1:0] CH_RANGE = 2'd0;
	localparam logic [1:0] CH_PLUS  = 2'd1;
	localparam logic [1:0] CH_MINUS = 2'd2;
	localparam logic [1:0] CH_ADX   = 2'd3;

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_PREP      = 13'b0000000000010,
		S_SEED      = 13'b0000000000100,
		S_WPRE      = 13'b0000000001000,
		S_WDIV      = 13'b0000000010000,
		S_DI_START  = 13'b0000000100000,
		S_DI_WAIT   = 13'b0000001000000,
		S_DX_START  = 13'b0000010000000,
		S_DX_WAIT   = 13'b0000100000000,
		S_TOT       = 13'b0001000000000,
		S_AVG_START = 13'b0010000000000,
		S_AVG_WAIT  = 13'b0100000000000,
		S_FIN       = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] idx_q;

	// Series state.
	logic [PB-1:0] prev_high_q, prev_low_q, prev_close_q;
	logic [CB-1:0] bar_count_q;
	logic [SB-1:0] range_q, plus_q, minus_q;
	logic [XB-1:0] dx_total_q;
	logic [OB-1:0] adx_run_q;

	// Current bar and its intermediate values.
	logic [PB-1:0] high_q, low_q, close_q;
	logic [MB-1:0] xr_q, xp_q, xm_q;
	logic [CB-1:0] k_q;
	logic          partial_q, kp_eq_q, ge_q;
	logic [OB-1:0] dx_q;
	logic [OB-1:0] pdi_q, mdi_q, adx_q;
	logic [1:0]    phase_q;

	// Divider interface.
	dmadx_pkg::div_req_t div_req;
	dmadx_pkg::div_rsp_t div_rsp;
	logic [DN-1:0]       div_dividend;
	logic [SB-1:0]       div_divisor;
	logic [DQ-1:0]       quot;

	// Bar analysis.
	logic [TB-1:0]        p_eff, p_m1;
	logic [CB-1:0]        p_ext, k_c;
	logic                 beyond, first, seed_c, partial_c;
	logic signed [PB:0]   hs, ls, phs, pls, pcs;
	logic signed [PB:0]   d_hl, d_hc, d_lc, a_hc, a_lc, tr, up, down;
	logic [MB-1:0]        xr_c, xp_c, xm_c;

	// Channel arithmetic.
	logic [SB-1:0]        s_sel, x_sel;
	logic [DQ-1:0]        seed_sum, w_num, w_new;
	logic                 ge_c;
	logic [SB-1:0]        seed_res;
	logic [OB-1:0]        w_cap;
	logic [SB-1:0]        di_a;
	logic [SB+HB-1:0]     di_x100;
	logic [OB:0]          di_sum;
	logic [OB-1:0]        di_diff;
	logic [OB+HB-1:0]     dx_x100;
	logic [XB:0]          dxt_sum;
	logic [XB-1:0]        dxt_res;

	assign p_eff = (period == '0) ? TB'(1) : period;
	assign p_m1  = p_eff - 1'b1;
	assign p_ext = {{(CB-TB){1'b0}}, p_eff};

	assign beyond    = bar_count_q == {CB{1'b1}};
	assign first     = !beyond && bar_count_q == '0;
	assign seed_c    = !beyond && bar_count_q <= p_ext;
	assign k_c       = bar_count_q - p_ext;
	assign partial_c = !beyond && k_c <= p_ext;

	assign hs  = $signed({1'b0, high_q});
	assign ls  = $signed({1'b0, low_q});
	assign phs = $signed({1'b0, prev_high_q});
	assign pls = $signed({1'b0, prev_low_q});
	assign pcs = $signed({1'b0, prev_close_q});

	always_comb begin
		d_hl = hs - ls;
		d_hc = hs - pcs;
		d_lc = ls - pcs;
		a_hc = d_hc[PB] ? -d_hc : d_hc;
		a_lc = d_lc[PB] ? -d_lc : d_lc;
		tr   = d_hl;
		if (a_hc > tr) begin
			tr = a_hc;
		end
		if (a_lc > tr) begin
			tr = a_lc;
		end
		up   = hs - phs;
		down = pls - ls;
	end

	// The true range is never negative, so its low bits carry the value.
	assign xr_c = {tr[PB-1:0], {FB{1'b0}}};
	assign xp_c = (up > down && !up[PB] && up != '0) ? {up[PB-1:0], {FB{1'b0}}} : '0;
	assign xm_c = (down > up && !down[PB] && down != '0) ? {down[PB-1:0], {FB{1'b0}}} : '0;

	always_comb begin
		unique case (idx_q)
			CH_RANGE: begin
				s_sel = range_q;
				x_sel = {{(SB-MB){1'b0}}, xr_q};
			end
			CH_PLUS: begin
				s_sel = plus_q;
				x_sel = {{(SB-MB){1'b0}}, xp_q};
			end
			CH_MINUS: begin
				s_sel = minus_q;
				x_sel = {{(SB-MB){1'b0}}, xm_q};
			end
			default: begin
				s_sel = {{(SB-OB){1'b0}}, adx_run_q};
				x_sel = {{(SB-OB){1'b0}}, dx_q};
			end
		endcase
	end

	assign seed_sum = {1'b0, s_sel} + {1'b0, x_sel};
	assign seed_res = seed_sum[SB] ? {SB{1'b1}} : seed_sum[SB-1:0];

	// Wilder step: s - ceil((s - x) / p) when s >= x, else s + (x - s) / p.
	assign ge_c  = s_sel >= x_sel;
	assign w_num = ge_c ? ({1'b0, s_sel} - {1'b0, x_sel} + {{(DQ-TB){1'b0}}, p_m1})
	                    : ({1'b0, x_sel} - {1'b0, s_sel});
	assign quot  = div_rsp.quotient;
	assign w_new = ge_q ? ({1'b0, s_sel} - quot) : ({1'b0, s_sel} + quot);
	assign w_cap = (w_new > FULL_Q) ? dmadx_pkg::FULL : w_new[OB-1:0];

	assign di_a    = (idx_q == CH_PLUS) ? plus_q : minus_q;
	assign di_x100 = {1'b0, di_a, 6'b0} + {2'b0, di_a, 5'b0} + {5'b0, di_a, 2'b0};
	assign di_sum  = {1'b0, pdi_q} + {1'b0, mdi_q};
	assign di_diff = (pdi_q > mdi_q) ? (pdi_q - mdi_q) : (mdi_q - pdi_q);
	assign dx_x100 = {1'b0, di_diff, 6'b0} + {2'b0, di_diff, 5'b0} + {5'b0, di_diff, 2'b0};

	assign dxt_sum = {1'b0, dx_total_q} + {{(XB+1-OB){1'b0}}, dx_q};
	assign dxt_res = dxt_sum[XB] ? {XB{1'b1}} : dxt_sum[XB-1:0];

	always_comb begin
		div_req      = '0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			S_WPRE: begin
				div_req.start  = 1'b1;
				div_req.narrow = idx_q == CH_ADX;
				div_dividend   = {{(DN-DQ){1'b0}}, w_num};
				div_divisor    = {{(SB-TB){1'b0}}, p_eff};
			end
			S_DI_START: begin
				div_req.start  = 1'b1;
				div_req.narrow = 1'b1;
				div_dividend   = {{(DN-SB-HB-FB){1'b0}}, di_x100, {FB{1'b0}}};
				div_divisor    = range_q;
			end
			S_DX_START: begin
				div_req.start  = 1'b1;
				div_req.narrow = 1'b1;
				div_dividend   = {{(DN-OB-HB-FB){1'b0}}, dx_x100, {FB{1'b0}}};
				div_divisor    = {{(SB-OB-1){1'b0}}, di_sum};
			end
			S_AVG_START: begin
				div_req.start  = 1'b1;
				div_req.narrow = 1'b1;
				div_dividend   = {{(DN-XB){1'b0}}, dx_total_q};
				div_divisor    = {{(SB-CB){1'b0}}, k_q};
			end
			default: begin
			end
		endcase
	end

	dmadx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.rsp      (div_rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (bar_accept) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (first) begin
					state_d = S_FIN;
				end else if (seed_c) begin
					state_d = S_SEED;
				end else begin
					state_d = S_WPRE;
				end
			end
			S_SEED: begin
				if (idx_q == CH_MINUS) begin
					state_d = S_FIN;
				end
			end
			S_WPRE: state_d = S_WDIV;
			S_WDIV: begin
				if (div_rsp.done) begin
					if (idx_q == CH_MINUS) begin
						state_d = S_DI_START;
					end else if (idx_q == CH_ADX) begin
						state_d = S_FIN;
					end else begin
						state_d = S_WPRE;
					end
				end
			end
			S_DI_START: state_d = S_DI_WAIT;
			S_DI_WAIT: begin
				if (div_rsp.done) begin
					state_d = (idx_q == CH_MINUS) ? S_DX_START : S_DI_START;
				end
			end
			S_DX_START: state_d = S_DX_WAIT;
			S_DX_WAIT: begin
				if (div_rsp.done) begin
					state_d = partial_q ? S_TOT : S_WPRE;
				end
			end
			S_TOT: state_d = S_AVG_START;
			S_AVG_START: state_d = S_AVG_WAIT;
			S_AVG_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= CH_RANGE;
			prev_high_q  <= '0;
			prev_low_q   <= '0;
			prev_close_q <= '0;
			bar_count_q  <= '0;
			range_q      <= '0;
			plus_q       <= '0;
			minus_q      <= '0;
			dx_total_q   <= '0;
			adx_run_q    <= '0;
			pdi_q        <= '0;
			mdi_q        <= '0;
			adx_q        <= '0;
			phase_q      <= dmadx_pkg::PHASE_WARM;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (bar_accept) begin
						pdi_q   <= '0;
						mdi_q   <= '0;
						adx_q   <= '0;
						phase_q <= dmadx_pkg::PHASE_WARM;
						if (bar.restart) begin
							prev_high_q  <= '0;
							prev_low_q   <= '0;
							prev_close_q <= '0;
							bar_count_q  <= '0;
							range_q      <= '0;
							plus_q       <= '0;
							minus_q      <= '0;
							dx_total_q   <= '0;
							adx_run_q    <= '0;
						end
					end
				end
				S_PREP: begin
					prev_high_q  <= high_q;
					prev_low_q   <= low_q;
					prev_close_q <= close_q;
					if (!beyond) begin
						bar_count_q <= bar_count_q + 1'b1;
					end
					idx_q <= CH_RANGE;
				end
				S_SEED: begin
					unique case (idx_q)
						CH_RANGE: range_q <= seed_res;
						CH_PLUS:  plus_q  <= seed_res;
						default:  minus_q <= seed_res;
					endcase
					idx_q <= idx_q + 1'b1;
				end
				S_WDIV: begin
					if (div_rsp.done) begin
						unique case (idx_q)
							CH_RANGE: begin
								range_q <= w_new[SB-1:0];
								idx_q   <= CH_PLUS;
							end
							CH_PLUS: begin
								plus_q <= w_new[SB-1:0];
								idx_q  <= CH_MINUS;
							end
							CH_MINUS: begin
								minus_q <= w_new[SB-1:0];
								idx_q   <= CH_PLUS;
							end
							default: begin
								adx_run_q <= w_cap;
								adx_q     <= w_cap;
								phase_q   <= dmadx_pkg::PHASE_SMOOTH;
							end
						endcase
					end
				end
				S_DI_WAIT: begin
					if (div_rsp.done) begin
						if (idx_q == CH_PLUS) begin
							pdi_q <= quot[OB-1:0];
							idx_q <= CH_MINUS;
						end else begin
							mdi_q <= quot[OB-1:0];
						end
					end
				end
				S_DX_WAIT: begin
					if (div_rsp.done && !partial_q) begin
						idx_q <= CH_ADX;
					end
				end
				S_TOT: dx_total_q <= dxt_res;
				S_AVG_WAIT: begin
					if (div_rsp.done) begin
						adx_q <= quot[OB-1:0];
						if (kp_eq_q) begin
							adx_run_q <= quot[OB-1:0];
							phase_q   <= dmadx_pkg::PHASE_SMOOTH;
						end else begin
							phase_q   <= dmadx_pkg::PHASE_PARTIAL;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && bar_accept) begin
			high_q  <= bar.bar_high;
			low_q   <= bar.bar_low;
			close_q <= bar.bar_close;
		end
		if (state_q == S_PREP) begin
			xr_q      <= xr_c;
			xp_q      <= xp_c;
			xm_q      <= xm_c;
			k_q       <= k_c;
			partial_q <= partial_c;
			kp_eq_q   <= k_c == p_ext;
		end
		if (state_q == S_WPRE) begin
			ge_q <= ge_c;
		end
		if (state_q == S_DX_WAIT && div_rsp.done) begin
			dx_q <= quot[OB-1:0];
		end
	end

	assign status.busy = state_q != S_IDLE;
	assign status.fin  = state_q == S_FIN;

	assign result.adx_value = adx_q;
	assign result.plus_di   = pdi_q;
	assign result.minus_di  = mdi_q;
	assign result.phase     = phase_q;

endmodule

### rtl/core/directional_movement_adx.sv
// ----------------------------------------------------------------------------
// directional_movement_adx: Wilder directional movement index per price bar
// Takes one bar at a time and returns ADX, +DI and -DI in unsigned Q7.16
// for the series so far, with the smoothing period set over APB.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                      Payload
// bar      in   bar_valid / bar_stall          dmadx_pkg::bar_t
// result   out  result_valid / result_stall    dmadx_pkg::result_t
// config   in   psel penable pwrite pready     period_bars at byte address 0
//
// A bar past the seed runs three 61-step and four 24-step divisions on the
// shared bit-serial divider, which retires one quotient bit per cycle.
// bar_stall is high from the transfer of a bar until its result is handed to
// the output register; a result waiting there does not hold off the next bar
// unless the sequencer has another result ready. Reset clears all series
// state and sets the period to 14 bars.
// ----------------------------------------------------------------------------
module directional_movement_adx (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                bar_valid,
	output logic                bar_stall,
	input  dmadx_pkg::bar_t     bar_data,
	output logic                result_valid,
	input  logic                result_stall,
	output dmadx_pkg::result_t  result_data
);

	localparam int TB = dmadx_pkg::PERIOD_BITS;
	localparam logic REG_PERIOD = 1'b0;

	logic [TB-1:0]          period_q;
	logic                   cfg_write;
	logic                   bar_accept;
	logic                   take;
	logic                   result_valid_q;
	dmadx_pkg::result_t     result_q;
	dmadx_pkg::seq_status_t status;
	dmadx_pkg::result_t     seq_result;

	// The low two address bits take no part in decode.
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PERIOD);
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_PERIOD) ? {{(32-TB){1'b0}}, period_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= dmadx_pkg::PERIOD_RESET;
		end else if (cfg_write) begin
			period_q <= pwdata[TB-1:0];
		end
	end

	assign bar_stall  = status.busy;
	assign bar_accept = bar_valid && !bar_stall;
	assign take       = !result_valid_q || !result_stall;

	dmadx_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.bar_accept (bar_accept),
		.bar        (bar_data),
		.period     (period_q),
		.take       (take),
		.status     (status),
		.result     (seq_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (status.fin && take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.fin && take) begin
			result_q <= seq_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

### rtl/core/dmadx_chk.sv
// ----------------------------------------------------------------------------
// dmadx_chk: port-level checks for the directional movement block
// Watches the bar and result channels of the top level over time; bound to
// every instance of the top level.
// ----------------------------------------------------------------------------
module dmadx_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                bar_valid,
	input  logic                bar_stall,
	input  logic                result_valid,
	input  logic                result_stall,
	input  dmadx_pkg::result_t  result_data
);

	// One bar at a time: a transfer always leaves the block busy.
	a_busy_after_bar: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && !bar_stall |=> bar_stall)
		else $error("bar channel not stalled after a bar transfer");

	// A new result shows up exactly as the sequencer returns to idle.
	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !bar_stall)
		else $error("result appeared while the block is still busy");

	a_warm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.phase == dmadx_pkg::PHASE_WARM |->
		result_data.adx_value == '0 && result_data.plus_di == '0 &&
		result_data.minus_di == '0)
		else $error("warming result carries nonzero values");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		result_data.adx_value <= dmadx_pkg::FULL &&
		result_data.plus_di <= dmadx_pkg::FULL &&
		result_data.minus_di <= dmadx_pkg::FULL &&
		(result_data.phase == dmadx_pkg::PHASE_WARM ||
		 result_data.phase == dmadx_pkg::PHASE_PARTIAL ||
		 result_data.phase == dmadx_pkg::PHASE_SMOOTH))
		else $error("result outside its range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result changed");

endmodule

bind directional_movement_adx dmadx_chk u_dmadx_chk (.*);
